// ===== sv/bplc_pkg.sv =====
// Shared constants, types and command/status structs for the busy period limit controller.
package bplc_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 20;
  localparam int unsigned PERIOD_BITS_DEF = 16;

  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned IDLE_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CEILING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_MODEL_MODE = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000000;
  localparam logic [LIMIT_W-1:0] UPPER_RESET = 32'd10000000;
  localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

  localparam logic [1:0] DEC_NONE = 2'd0;
  localparam logic [1:0] DEC_EMERGENCY = 2'd1;
  localparam logic [1:0] DEC_RECOVERY = 2'd2;
  localparam logic [1:0] DEC_CONTENTION = 2'd3;

  typedef struct packed {
    logic start;       // latch sample, update run counters
    logic close_begin; // record period, start history scan
    logic scan_step;   // compare one ring entry
    logic decide;      // evaluate ratio thresholds
    logic div_start;   // start the emergency divide
    logic div_step;    // one restoring divide step
    logic cut_apply;   // write emergency limit
  } bplc_cmd_t;

  typedef struct packed {
    logic closing;   // sample closes a busy period
    logic scan_last; // scan at final ring entry
    logic emergency; // emergency condition holds
    logic div_done;  // divider finished
  } bplc_sts_t;

endpackage

// ===== sv/bplc_ctrl.sv =====
// Sequencer for the busy period limit controller: sample, scan, decide, divide, deliver.
module bplc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bplc_pkg::bplc_cmd_t cmd,
  input  bplc_pkg::bplc_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.closing) begin
          cmd.close_begin = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.emergency) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.cut_apply = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/bplc_dp.sv =====
// Datapath for the busy period limit controller: counters, history ring, ratio test, divider.
module bplc_dp #(
  parameter int unsigned HISTORY_DEPTH = bplc_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned PERIOD_BITS = bplc_pkg::PERIOD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [31:0]                         sample_count,
  input  logic                                cfg_we,
  input  logic [bplc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  input  bplc_pkg::bplc_cmd_t                 cmd,
  output bplc_pkg::bplc_sts_t                 sts,
  output logic [bplc_pkg::IDLE_W-1:0]         idle_run,
  output logic [bplc_pkg::LIMIT_W-1:0]        shared_limit,
  output logic [1:0]                          decision
);

  localparam int unsigned POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned QW = 32 + PERIOD_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(QW + 1);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
  localparam logic [PERIOD_BITS-1:0] HIST_CAP = (PERIOD_BITS >= 10) ? PERIOD_BITS'(1000) : '1;
  localparam logic [PERIOD_BITS-1:0] NOISE_LEN = PERIOD_BITS'(6);
  localparam logic [2:0] RECOVER_EVERY = 3'd5;
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

  logic [31:0] limit_ceiling;
  logic [31:0] emergency_floor;
  logic        large_model_mode;

  logic                      prev_busy;
  logic                      busy;
  logic                      closing_r;
  logic [PERIOD_BITS-1:0]    busy_run;
  logic [bplc_pkg::IDLE_W-1:0] idle_count;
  logic [PERIOD_BITS-1:0]    min_seen;
  logic [PERIOD_BITS-1:0]    max_seen;
  logic [PERIOD_BITS-1:0]    period_ring [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]  ring_valid;
  logic [POS_W-1:0]          ring_pos;
  logic [2:0]                ring_mod5;
  logic [31:0]               limit_value;
  logic [1:0]                dec;

  logic [PERIOD_BITS-1:0]    period;
  logic [PERIOD_BITS-1:0]    hmin;
  logic [CNT_W-1:0]          scan_idx;

  logic [QW-1:0]             dividend;
  logic [PERIOD_BITS:0]      rem;
  logic [DIV_CNT_W-1:0]      div_cnt;

  logic [PERIOD_BITS-1:0]    scan_val;
  logic [PERIOD_BITS-1:0]    hmin_fix;
  logic [PERIOD_BITS-1:0]    d_sel;
  logic [PERIOD_BITS+3:0]    p10;
  logic [PERIOD_BITS+3:0]    d_thr;
  logic [PERIOD_BITS+3:0]    d12;
  logic [PERIOD_BITS+2:0]    d4;
  logic                      emerg;
  logic                      recov;
  logic [31:0]               tenth_in;
  logic [63:0]               tenth_prod;
  logic [31:0]               tenth;
  logic [31:0]               floor_tenth;
  logic [31:0]               lim_tenth;
  logic [31:0]               lim_rem;
  logic [5:0]                rem_r3;
  logic [3:0]                grown_extra;
  logic [35:0]               grown;
  logic [31:0]               grown32;
  logic [31:0]               floor_val;
  logic [31:0]               cut;
  logic [PERIOD_BITS:0]      rem_sh;
  logic                      rem_ge;
  logic [QW-1:0]             quo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_ceiling <= bplc_pkg::UPPER_RESET;
      emergency_floor <= '0;
      large_model_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bplc_pkg::REG_LIMIT_CEILING: limit_ceiling <= cfg_data;
        bplc_pkg::REG_EMERGENCY_FLOOR: emergency_floor <= cfg_data;
        bplc_pkg::REG_LARGE_MODEL_MODE: large_model_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign scan_val = (ring_valid[scan_idx[POS_W-1:0]])
                    ? period_ring[scan_idx[POS_W-1:0]] : '0;
  assign hmin_fix = (hmin > PERIOD_BITS'(1)) ? hmin : PERIOD_BITS'(2);
  assign d_sel = (large_model_mode && (min_seen != '0)) ? hmin_fix : min_seen;
  assign p10 = ({4'd0, period} << 3) + ({4'd0, period} << 1);
  assign d_thr = large_model_mode ? (({4'd0, d_sel} << 3) + ({4'd0, d_sel} << 2) + {4'd0, d_sel})
                                  : ({4'd0, d_sel} << 4);
  assign d12 = ({4'd0, d_sel} << 3) + ({4'd0, d_sel} << 2);
  assign d4 = {3'd0, d_sel} << 2;
  assign emerg = (d_sel != '0) && (p10 >= d_thr) && ({3'd0, period} < d4);
  assign recov = ((d_sel == '0) || (p10 < d12)) && (ring_mod5 == 3'd0);
  assign tenth_in = cmd.start ? emergency_floor : limit_value;
  assign tenth_prod = {32'd0, tenth_in} * {32'd0, DIV10_RECIP};
  assign tenth = {3'd0, tenth_prod[63:35]};
  assign lim_rem = limit_value - ((lim_tenth << 3) + (lim_tenth << 1));
  assign rem_r3 = {2'd0, lim_rem[3:0]} + {1'd0, lim_rem[3:0], 1'b0};
  assign grown_extra = lim_rem[3:0] + ((rem_r3 >= 6'd20) ? 4'd2 : ((rem_r3 >= 6'd10) ? 4'd1 : 4'd0));
  assign grown = ({4'd0, lim_tenth} << 3) + ({4'd0, lim_tenth} << 2) + {4'd0, lim_tenth}
                 + {32'd0, grown_extra};
  assign grown32 = (grown > {4'd0, limit_ceiling}) ? limit_ceiling : grown[31:0];
  assign floor_val = large_model_mode ? floor_tenth : emergency_floor;
  assign rem_sh = {rem[PERIOD_BITS-1:0], dividend[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, period};
  assign quo_full = dividend;
  assign cut = (|quo_full[QW-1:32]) ? 32'hFFFF_FFFF : quo_full[31:0];

  assign busy = (sample_count != '0);
  assign sts.closing = closing_r;
  assign sts.scan_last = (scan_idx == CNT_W'(HISTORY_DEPTH - 1));
  assign sts.emergency = emerg;
  assign sts.div_done = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_busy <= 1'b0;
      closing_r <= 1'b0;
      busy_run <= '0;
      idle_count <= '0;
      min_seen <= '0;
      max_seen <= '0;
      ring_valid <= '0;
      ring_pos <= '0;
      ring_mod5 <= '0;
      limit_value <= bplc_pkg::LIMIT_RESET;
      dec <= bplc_pkg::DEC_NONE;
    end else begin
      if (cmd.start) begin
        dec <= bplc_pkg::DEC_NONE;
        period <= busy_run;
        closing_r <= !busy && prev_busy;
        if (busy) begin
          if (!prev_busy) begin
            idle_count <= '0;
          end
          if (busy_run < PERIOD_MAX) busy_run <= busy_run + 1'b1;
        end else begin
          if (prev_busy) busy_run <= '0;
          if (!prev_busy || idle_count != '0) begin
            if (idle_count < bplc_pkg::IDLE_MAX) idle_count <= idle_count + 1'b1;
          end else begin
            idle_count <= idle_count + 1'b1;
          end
        end
      end
      if (cmd.close_begin) begin
        prev_busy <= 1'b0;
        if (period > max_seen) begin
          max_seen <= period;
        end
        if (((period > max_seen) && (min_seen == '0) && (period > NOISE_LEN))
            || ((min_seen > period) && (period > NOISE_LEN))) begin
          min_seen <= period;
        end
        ring_valid[ring_pos] <= 1'b1;
        ring_pos <= (ring_pos == POS_W'(HISTORY_DEPTH - 1)) ? '0 : ring_pos + 1'b1;
        ring_mod5 <= (ring_pos == POS_W'(HISTORY_DEPTH - 1)) ? 3'd0
                   : ((ring_mod5 == RECOVER_EVERY - 3'd1) ? 3'd0 : ring_mod5 + 3'd1);
      end else if (cmd.start) begin
        prev_busy <= busy;
      end
      if (cmd.decide) begin
        if (emerg) begin
          dec <= bplc_pkg::DEC_EMERGENCY;
        end else if (recov) begin
          dec <= bplc_pkg::DEC_RECOVERY;
          limit_value <= grown32;
        end else begin
          dec <= bplc_pkg::DEC_CONTENTION;
        end
      end
      if (cmd.cut_apply) begin
        limit_value <= (floor_val > cut) ? floor_val : cut;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close_begin) begin
      period_ring[ring_pos] <= period;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      floor_tenth <= tenth;
    end
    if (cmd.close_begin) begin
      lim_tenth <= tenth;
      scan_idx <= '0;
      hmin <= HIST_CAP;
    end else if (cmd.scan_step) begin
      if (scan_val != '0 && scan_val < hmin) hmin <= scan_val;
      if (!sts.scan_last) scan_idx <= scan_idx + 1'b1;
    end
  end

  // restoring divide of limit*D by period, one quotient bit per step
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DIV_CNT_W'(QW);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend <= QW'(limit_value) * QW'(d_sel);
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? (rem_sh - {1'b0, period}) : rem_sh;
      dividend <= {dividend[QW-2:0], rem_ge};
    end
  end

  assign idle_run = idle_count;
  assign shared_limit = limit_value;
  assign decision = dec;

endmodule

// ===== sv/busy_period_limit_controller_unit.sv =====
// Top level of the busy period limit controller: sequencer plus datapath.
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | sample_count
//   out     | output    | out_valid / out_ready | idle_run, shared_limit, decision
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
// A sample with no closing period passes through accept, check and the result beat.
// A closing period adds a scan of every ring entry plus a decide step and,
// on an emergency, a bit-serial divide of limit times reference by the period.
// rst clears control state, not ring data; the result beat holds until out_ready.
module busy_period_limit_controller_unit #(
  parameter int unsigned HISTORY_DEPTH = bplc_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned PERIOD_BITS = bplc_pkg::PERIOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    sample_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bplc_pkg::IDLE_W-1:0]    idle_run,
  output logic [bplc_pkg::LIMIT_W-1:0]   shared_limit,
  output logic [1:0]                     decision,
  input  logic                           cfg_we,
  input  logic [bplc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  bplc_pkg::bplc_cmd_t cmd;
  bplc_pkg::bplc_sts_t sts;

  bplc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  bplc_dp #(.HISTORY_DEPTH(HISTORY_DEPTH), .PERIOD_BITS(PERIOD_BITS)) u_dp (
    .clk(clk), .rst(rst), .sample_count(sample_count), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
    .idle_run(idle_run), .shared_limit(shared_limit), .decision(decision)
  );

endmodule

// ===== sv/bplc_checker.sv =====
// Port-level checks for the busy period limit controller, bound to the top level.
module bplc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] shared_limit,
  input logic [1:0]  decision
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shared_limit) && $stable(decision))
    else $error("result beat changed while stalled");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");

  a_none_keeps_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && decision == bplc_pkg::DEC_NONE && $rose(out_valid)
    |-> shared_limit == $past(shared_limit, 1)) else $error("limit moved with no period");

endmodule

bind busy_period_limit_controller_unit bplc_checker u_bplc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .shared_limit(shared_limit), .decision(decision)
);
